// ===== sv/lat_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lat_pkg: shared types and constants of the toroidal life automaton
// grid geometry, command and register codes, sequencer states
// ----------------------------------------------------------------------------
package lat_pkg;

	// grid storage, one memory row per grid row
	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 64;

	// fixed field widths
	localparam int SIZE_W    = 7;
	localparam int GEN_W     = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CMD_W     = 2;
	localparam int IDX_W     = 6;

	localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int COL_AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

	// holds the size registers and the maximum sizes
	localparam int CMP_W = $clog2(((MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS) + 128);

	// read steps of one generation: wrapped window, then copy of unused rows
	localparam int STEP_W    = $clog2(MAX_ROWS + 2);
	localparam int LAST_STEP = MAX_ROWS + 1;

	typedef logic [MAX_COLS-1:0] row_t;

	typedef logic [CMD_W-1:0] cmd_t;
	localparam cmd_t CMD_WRITE  = 2'd0;
	localparam cmd_t CMD_EVOLVE = 2'd1;
	localparam cmd_t CMD_READ   = 2'd2;

	typedef logic [CFG_IDX_W-1:0] reg_idx_t;
	localparam reg_idx_t REG_GRID_ROWS = 2'd0;
	localparam reg_idx_t REG_GRID_COLS = 2'd1;
	localparam reg_idx_t REG_GEN_COUNT = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CELL,
		ST_GEN,
		ST_DRAIN
	} state_t;

endpackage
`default_nettype wire

// ===== sv/lat_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lat_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module lat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== sv/life_automaton_torus_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// life_automaton_torus_unit: toroidal b3/s23 life grid
// cell write, cell read and multi-generation evolve over a ping-pong row store
// ----------------------------------------------------------------------------
//
//  channel   handshake            word / fields
//  -------   ------------------   ---------------------------------------
//  req       req_valid/req_ready  cmd, row_index, col_index, cell_in
//  rsp       rsp_valid/rsp_ready  cell_out, index_error
//  cfg       cfg_we               cfg_index, cfg_data (no wait, no readback)
//
//  steps: a cell write or read word reads its row, then does the bit select
//  or read-modify-write; an out-of-range or unused word answers from idle
//  with no row read. an evolve word reads MAX_ROWS + 2 rows per generation
//  through the single read port of the row store: the last used row and row 0
//  twice, all other rows once. reset: a clearing pass writes zero rows to all
//  MAX_ROWS rows of both banks, req_ready low. stalls: req_ready is low while
//  a word is in work and while rsp holds a word that is not being taken.
//
module life_automaton_torus_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// request channel
	input  wire logic                            req_valid,
	output logic                                 req_ready,
	input  wire logic [lat_pkg::CMD_W-1:0]       cmd,
	input  wire logic [lat_pkg::IDX_W-1:0]       row_index,
	input  wire logic [lat_pkg::IDX_W-1:0]       col_index,
	input  wire logic                            cell_in,
	// response channel
	output logic                                 rsp_valid,
	input  wire logic                            rsp_ready,
	output logic                                 cell_out,
	output logic                                 index_error,
	// configuration writes
	input  wire logic                            cfg_we,
	input  wire logic [lat_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [lat_pkg::CFG_W-1:0]       cfg_data
);

	// new generation of one row from its wrapped neighbor rows
	function automatic lat_pkg::row_t life_row(
		input lat_pkg::row_t                   north,
		input lat_pkg::row_t                   mid,
		input lat_pkg::row_t                   south,
		input logic [lat_pkg::CMP_W-1:0]       cols
	);
		lat_pkg::row_t                nw, ne, mw, me, sw, se, res;
		logic [lat_pkg::COL_AW-1:0]   last;
		logic [3:0]                   cnt;
		last = lat_pkg::COL_AW'(cols - lat_pkg::CMP_W'(1));
		// rotate by one lane, then patch the seam at the used width
		nw = {north[lat_pkg::MAX_COLS-2:0], north[lat_pkg::MAX_COLS-1]};
		mw = {mid[lat_pkg::MAX_COLS-2:0], mid[lat_pkg::MAX_COLS-1]};
		sw = {south[lat_pkg::MAX_COLS-2:0], south[lat_pkg::MAX_COLS-1]};
		ne = {north[0], north[lat_pkg::MAX_COLS-1:1]};
		me = {mid[0], mid[lat_pkg::MAX_COLS-1:1]};
		se = {south[0], south[lat_pkg::MAX_COLS-1:1]};
		nw[0] = north[last];
		mw[0] = mid[last];
		sw[0] = south[last];
		ne[last] = north[0];
		me[last] = mid[0];
		se[last] = south[0];
		for (int c = 0; c < lat_pkg::MAX_COLS; c++) begin
			cnt = 4'(nw[c]) + 4'(north[c]) + 4'(ne[c]) + 4'(mw[c]) + 4'(me[c])
				+ 4'(sw[c]) + 4'(south[c]) + 4'(se[c]);
			if (lat_pkg::CMP_W'(c) < cols) begin
				res[c] = (cnt == 4'd3) || (mid[c] && (cnt == 4'd2));
			end else begin
				res[c] = mid[c];
			end
		end
		return res;
	endfunction

	// configuration registers
	logic [lat_pkg::SIZE_W-1:0]   grid_rows_q;
	logic [lat_pkg::SIZE_W-1:0]   grid_cols_q;
	logic [lat_pkg::GEN_W-1:0]    generation_count_q;
	logic [lat_pkg::CMP_W-1:0]    rows_eff;
	logic [lat_pkg::CMP_W-1:0]    cols_eff;

	// sequencer
	lat_pkg::state_t              state_q, state_d;
	lat_pkg::cmd_t                cmd_q;
	logic [lat_pkg::ROW_AW-1:0]   row_q;
	logic [lat_pkg::COL_AW-1:0]   col_q;
	logic                         val_q;
	logic [lat_pkg::ROW_AW-1:0]   clear_cnt_q;
	logic [lat_pkg::STEP_W-1:0]   step_q;
	logic [lat_pkg::GEN_W-1:0]    gen_left_q;
	logic                         changed_q;
	logic                         cur_bank_q;

	// strobes from the sequencer
	logic                         accept;
	logic                         req_oob;
	logic                         issue;
	logic                         evolve_start;
	logic                         gen_restart;
	logic                         gen_flip;
	logic                         cell_we;
	logic                         rsp_load;
	logic                         rsp_cell_d;
	logic                         rsp_err_d;

	// read step decode
	logic [lat_pkg::CMP_W-1:0]    step_ext;
	logic [lat_pkg::ROW_AW-1:0]   gen_raddr;
	logic                         copy_d;
	logic                         wr_en_d;
	logic [lat_pkg::ROW_AW-1:0]   wr_row_d;

	// sweep pipeline: s1 read data arrives, s2 row written
	logic                         rd_valid_s1, rd_valid_s2;
	logic                         wr_en_s1, wr_en_s2;
	logic                         copy_s1, copy_s2;
	logic [lat_pkg::ROW_AW-1:0]   wr_row_s1, wr_row_s2;
	lat_pkg::row_t                win_north_q, win_mid_q, win_south_q;
	lat_pkg::row_t                life_new;
	logic                         gen_we;
	lat_pkg::row_t                gen_wdata;

	// row stores
	logic [lat_pkg::ROW_AW-1:0]   ram_raddr;
	logic [lat_pkg::ROW_AW-1:0]   ram_waddr;
	lat_pkg::row_t                ram_wdata;
	logic                         we_a, we_b;
	lat_pkg::row_t                rdata_a, rdata_b, rdata_cur;
	lat_pkg::row_t                cell_wdata;

	// response register
	logic                         rsp_valid_q;
	logic                         cell_out_q;
	logic                         index_error_q;

	// sizes in use: zero counts as one, large values saturate
	always_comb begin
		if (grid_rows_q == '0) begin
			rows_eff = lat_pkg::CMP_W'(1);
		end else if (lat_pkg::CMP_W'(grid_rows_q) > lat_pkg::CMP_W'(lat_pkg::MAX_ROWS)) begin
			rows_eff = lat_pkg::CMP_W'(lat_pkg::MAX_ROWS);
		end else begin
			rows_eff = lat_pkg::CMP_W'(grid_rows_q);
		end
		if (grid_cols_q == '0) begin
			cols_eff = lat_pkg::CMP_W'(1);
		end else if (lat_pkg::CMP_W'(grid_cols_q) > lat_pkg::CMP_W'(lat_pkg::MAX_COLS)) begin
			cols_eff = lat_pkg::CMP_W'(lat_pkg::MAX_COLS);
		end else begin
			cols_eff = lat_pkg::CMP_W'(grid_cols_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q        <= lat_pkg::SIZE_W'(64);
			grid_cols_q        <= lat_pkg::SIZE_W'(64);
			generation_count_q <= lat_pkg::GEN_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				lat_pkg::REG_GRID_ROWS: grid_rows_q <= cfg_data[lat_pkg::SIZE_W-1:0];
				lat_pkg::REG_GRID_COLS: grid_cols_q <= cfg_data[lat_pkg::SIZE_W-1:0];
				lat_pkg::REG_GEN_COUNT: generation_count_q <= cfg_data[lat_pkg::GEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign req_oob = (lat_pkg::CMP_W'(row_index) >= rows_eff)
		|| (lat_pkg::CMP_W'(col_index) >= cols_eff);

	// sweep order per generation: row n-1, rows 0..n-1, row 0 to fill the
	// wrapped window, then rows n..MAX_ROWS-1 copied unchanged
	always_comb begin
		step_ext = lat_pkg::CMP_W'(step_q);
		if (step_ext == '0) begin
			gen_raddr = lat_pkg::ROW_AW'(rows_eff - lat_pkg::CMP_W'(1));
		end else if (step_ext <= rows_eff) begin
			gen_raddr = lat_pkg::ROW_AW'(step_ext - lat_pkg::CMP_W'(1));
		end else if (step_ext == rows_eff + lat_pkg::CMP_W'(1)) begin
			gen_raddr = '0;
		end else begin
			gen_raddr = lat_pkg::ROW_AW'(step_ext - lat_pkg::CMP_W'(2));
		end
		copy_d   = step_ext > (rows_eff + lat_pkg::CMP_W'(1));
		wr_en_d  = step_ext >= lat_pkg::CMP_W'(2);
		wr_row_d = lat_pkg::ROW_AW'(step_ext - lat_pkg::CMP_W'(2));
	end

	assign rdata_cur = cur_bank_q ? rdata_b : rdata_a;

	// next state and strobes
	always_comb begin
		state_d      = state_q;
		req_ready    = 1'b0;
		issue        = 1'b0;
		evolve_start = 1'b0;
		gen_restart  = 1'b0;
		gen_flip     = 1'b0;
		cell_we      = 1'b0;
		rsp_load     = 1'b0;
		rsp_cell_d   = 1'b0;
		rsp_err_d    = 1'b0;
		ram_raddr    = row_q;
		unique case (state_q)
			lat_pkg::ST_CLEAR: begin
				if (clear_cnt_q == lat_pkg::ROW_AW'(lat_pkg::MAX_ROWS - 1)) begin
					state_d = lat_pkg::ST_IDLE;
				end
			end
			lat_pkg::ST_IDLE: begin
				// response register is free or being emptied this cycle
				req_ready = !rsp_valid_q || rsp_ready;
				ram_raddr = lat_pkg::ROW_AW'(row_index);
				if (req_valid && req_ready) begin
					case (cmd)
						lat_pkg::CMD_WRITE, lat_pkg::CMD_READ: begin
							if (req_oob) begin
								rsp_load  = 1'b1;
								rsp_err_d = 1'b1;
							end else begin
								state_d = lat_pkg::ST_CELL;
							end
						end
						lat_pkg::CMD_EVOLVE: begin
							if (generation_count_q == '0) begin
								rsp_load = 1'b1;
							end else begin
								evolve_start = 1'b1;
								state_d      = lat_pkg::ST_GEN;
							end
						end
						default: rsp_load = 1'b1;
					endcase
				end
			end
			lat_pkg::ST_CELL: begin
				// row is in rdata_cur now
				rsp_load = 1'b1;
				if (cmd_q == lat_pkg::CMD_READ) begin
					rsp_cell_d = rdata_cur[col_q];
				end else begin
					cell_we = 1'b1;
				end
				state_d = lat_pkg::ST_IDLE;
			end
			lat_pkg::ST_GEN: begin
				issue     = 1'b1;
				ram_raddr = gen_raddr;
				if (step_ext == lat_pkg::CMP_W'(lat_pkg::LAST_STEP)) begin
					state_d = lat_pkg::ST_DRAIN;
				end
			end
			lat_pkg::ST_DRAIN: begin
				// last row written once the pipeline is empty
				if (!rd_valid_s1 && !rd_valid_s2) begin
					gen_flip = 1'b1;
					if (!changed_q || (gen_left_q == lat_pkg::GEN_W'(1))) begin
						rsp_load = 1'b1;
						state_d  = lat_pkg::ST_IDLE;
					end else begin
						gen_restart = 1'b1;
						state_d     = lat_pkg::ST_GEN;
					end
				end
			end
			default: state_d = lat_pkg::ST_CLEAR;
		endcase
	end

	assign accept = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lat_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_cnt_q <= '0;
			step_q      <= '0;
			gen_left_q  <= '0;
			changed_q   <= 1'b0;
			cur_bank_q  <= 1'b0;
		end else begin
			if (state_q == lat_pkg::ST_CLEAR) begin
				clear_cnt_q <= clear_cnt_q + lat_pkg::ROW_AW'(1);
			end
			if (evolve_start || gen_restart) begin
				step_q <= '0;
			end else if (issue) begin
				step_q <= step_q + lat_pkg::STEP_W'(1);
			end
			if (evolve_start) begin
				gen_left_q <= generation_count_q;
			end else if (gen_restart) begin
				gen_left_q <= gen_left_q - lat_pkg::GEN_W'(1);
			end
			if (evolve_start || gen_restart) begin
				changed_q <= 1'b0;
			end else if (gen_we && !copy_s2) begin
				changed_q <= changed_q | (|(life_new ^ win_mid_q));
			end
			if (gen_flip) begin
				cur_bank_q <= !cur_bank_q;
			end
		end
	end

	// latched request word
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			row_q <= lat_pkg::ROW_AW'(row_index);
			col_q <= lat_pkg::COL_AW'(col_index);
			val_q <= cell_in;
		end
	end

	// sweep pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
			rd_valid_s2 <= 1'b0;
		end else begin
			rd_valid_s1 <= issue;
			rd_valid_s2 <= rd_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		wr_en_s1  <= wr_en_d;
		copy_s1   <= copy_d;
		wr_row_s1 <= wr_row_d;
		wr_en_s2  <= wr_en_s1;
		copy_s2   <= copy_s1;
		wr_row_s2 <= wr_row_s1;
		// three-row window slides by one row per arriving read
		if (rd_valid_s1) begin
			win_north_q <= win_mid_q;
			win_mid_q   <= win_south_q;
			win_south_q <= rdata_cur;
		end
	end

	// evolved row, or the row just read when copying rows outside the grid
	assign life_new  = life_row(win_north_q, win_mid_q, win_south_q, cols_eff);
	assign gen_we    = rd_valid_s2 && wr_en_s2;
	assign gen_wdata = copy_s2 ? win_south_q : life_new;

	always_comb begin
		cell_wdata        = rdata_cur;
		cell_wdata[col_q] = val_q;
	end

	// write port: clearing pass to both, cell write to current, sweep to other
	always_comb begin
		we_a      = 1'b0;
		we_b      = 1'b0;
		ram_waddr = wr_row_s2;
		ram_wdata = gen_wdata;
		if (state_q == lat_pkg::ST_CLEAR) begin
			we_a      = 1'b1;
			we_b      = 1'b1;
			ram_waddr = clear_cnt_q;
			ram_wdata = '0;
		end else if (cell_we) begin
			we_a      = !cur_bank_q;
			we_b      = cur_bank_q;
			ram_waddr = row_q;
			ram_wdata = cell_wdata;
		end else if (gen_we) begin
			we_a      = cur_bank_q;
			we_b      = !cur_bank_q;
		end
	end

	lat_ram #(
		.WIDTH (lat_pkg::MAX_COLS),
		.DEPTH (lat_pkg::MAX_ROWS)
	) u_bank_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rdata_a)
	);

	lat_ram #(
		.WIDTH (lat_pkg::MAX_COLS),
		.DEPTH (lat_pkg::MAX_ROWS)
	) u_bank_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rdata_b)
	);

	// response word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			cell_out_q    <= rsp_cell_d;
			index_error_q <= rsp_err_d;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign cell_out    = cell_out_q;
	assign index_error = index_error_q;

endmodule
`default_nettype wire
